// File: hw/rtl/clld_pkg.sv
// Shared types and constants for the click and long-click detector.
// Used by the controller, the datapath and the top level; no dependencies.
package clld_pkg;

  localparam int NUM_BUTTONS_DEF = 3;
  localparam int COORD_BITS_DEF  = 16;

  localparam int TS_BITS  = 32;
  localparam int BTN_BITS = 2;
  localparam int CFG_BITS = 16;

  localparam logic [CFG_BITS-1:0] RADIUS_RST = 16'd8;
  localparam logic [CFG_BITS-1:0] DELAY_RST  = 16'd500;

  localparam logic [BTN_BITS-1:0] BTN_NONE = 2'd3;

  localparam logic REG_CLICK_RADIUS = 1'b0;
  localparam logic REG_LONG_DELAY   = 1'b1;

  typedef enum logic [1:0] {
    CMD_DOWN = 2'd0,
    CMD_UP   = 2'd1,
    CMD_MOVE = 2'd2
  } cmd_kind_t;

  typedef enum logic [2:0] {
    EV_DOWN  = 3'd0,
    EV_UP    = 3'd1,
    EV_LONG  = 3'd2,
    EV_CLICK = 3'd3,
    EV_MOVE  = 3'd4
  } ev_kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_DIFF,
    ST_SQUARE,
    ST_CHECK,
    ST_EMIT_ONE,
    ST_EMIT_UP,
    ST_EMIT_CLICK
  } state_t;

  typedef struct packed {
    logic     load;
    logic     set_pos;
    logic     apply_down;
    logic     apply_up;
    logic     move_start;
    logic     diff_en;
    logic     sq_en;
    logic     check_en;
    logic     emit;
    ev_kind_t emit_kind;
    logic     emit_last;
  } clld_cmd_t;

  typedef struct packed {
    logic is_down;
    logic is_up;
    logic is_move;
    logic btn_ok;
    logic armed_snap;
    logic long_snap;
    logic last_btn;
    logic out_free;
  } clld_sts_t;

endpackage

// File: hw/rtl/click_long_click_detector.sv
// Click and long-click detector, top level. Items are handled one at a time.
// A down or up beat passes decode and an emit state, and an ignored item only decode;
// an up is followed by a click result when the button is still armed, and a move
// runs one diff, square and compare per button before its emit state. The next
// beat is taken while a result waits in the output register.
// Synchronous active-low reset clears the button state, arms every button and resets the config registers.
module click_long_click_detector import clld_pkg::*; #(
  parameter int NUM_BUTTONS = NUM_BUTTONS_DEF,
  parameter int COORD_BITS  = COORD_BITS_DEF,
  localparam int IN_W  = ((2 * COORD_BITS + BTN_BITS + TS_BITS + 7) / 8) * 8,
  localparam int OUT_W = ((2 * COORD_BITS + BTN_BITS + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  // pos_x, pos_y, button_index, timestamp_ms
  input  logic [IN_W-1:0]  in_tdata,
  // command
  input  logic [1:0]       in_tuser,
  output logic             out_tvalid,
  input  logic             out_tready,
  // event_button, cur_x, cur_y
  output logic [OUT_W-1:0] out_tdata,
  // event_kind
  output logic [2:0]       out_tuser,
  output logic             out_tlast,
  input  logic             cfg_psel,
  input  logic             cfg_penable,
  input  logic             cfg_pwrite,
  input  logic [2:0]       cfg_paddr,
  input  logic [31:0]      cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  localparam int CB = COORD_BITS;

  logic [CFG_BITS-1:0] radius_r;
  logic [CFG_BITS-1:0] delay_r;
  logic                reg_idx;
  logic                cfg_wr;

  clld_cmd_t cmd;
  clld_sts_t sts;

  logic [BTN_BITS-1:0]  res_btn;
  logic signed [CB-1:0] res_x;
  logic signed [CB-1:0] res_y;

  assign cfg_pready = 1'b1;
  assign reg_idx    = cfg_paddr[2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= RADIUS_RST;
      delay_r  <= DELAY_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_CLICK_RADIUS: radius_r <= cfg_pwdata[CFG_BITS-1:0];
        REG_LONG_DELAY:   delay_r  <= cfg_pwdata[CFG_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_CLICK_RADIUS: cfg_prdata = 32'(radius_r);
      REG_LONG_DELAY:   cfg_prdata = 32'(delay_r);
      default:          cfg_prdata = '0;
    endcase
  end

  clld_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  clld_dp #(
    .NUM_BUTTONS (NUM_BUTTONS),
    .COORD_BITS  (COORD_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .in_cmd           (in_tuser),
    .in_x             (in_tdata[CB-1:0]),
    .in_y             (in_tdata[2*CB-1:CB]),
    .in_btn           (in_tdata[2*CB+BTN_BITS-1:2*CB]),
    .in_ts            (in_tdata[2*CB+BTN_BITS+TS_BITS-1:2*CB+BTN_BITS]),
    .click_radius     (radius_r),
    .long_click_delay (delay_r),
    .out_tready       (out_tready),
    .out_tvalid       (out_tvalid),
    .out_kind         (out_tuser),
    .out_btn          (res_btn),
    .out_x            (res_x),
    .out_y            (res_y),
    .out_last         (out_tlast)
  );

  assign out_tdata = OUT_W'({res_y, res_x, res_btn});

endmodule

// File: hw/rtl/clld_ctrl.sv
// Controller state machine of the click and long-click detector.
// Depends on clld_pkg; drives the datapath through clld_cmd_t.
module clld_ctrl import clld_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  input  clld_sts_t sts_i,
  output clld_cmd_t cmd_o
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (sts_i.is_move) begin
          state_nxt = ST_DIFF;
        end else if (sts_i.is_down && sts_i.btn_ok) begin
          state_nxt = ST_EMIT_ONE;
        end else if (sts_i.is_up && sts_i.btn_ok) begin
          state_nxt = ST_EMIT_UP;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_DIFF:   state_nxt = ST_SQUARE;
      ST_SQUARE: state_nxt = ST_CHECK;
      ST_CHECK: begin
        state_nxt = sts_i.last_btn ? ST_EMIT_ONE : ST_DIFF;
      end
      ST_EMIT_ONE: begin
        if (sts_i.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_EMIT_UP: begin
        if (sts_i.out_free) begin
          state_nxt = sts_i.armed_snap ? ST_EMIT_CLICK : ST_IDLE;
        end
      end
      ST_EMIT_CLICK: begin
        if (sts_i.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o     = '0;
    in_tready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready  = 1'b1;
        cmd_o.load = in_tvalid;
      end
      ST_DECODE: begin
        cmd_o.set_pos    = sts_i.is_move ||
                           ((sts_i.is_down || sts_i.is_up) && sts_i.btn_ok);
        cmd_o.apply_down = sts_i.is_down && sts_i.btn_ok;
        cmd_o.apply_up   = sts_i.is_up && sts_i.btn_ok;
        cmd_o.move_start = sts_i.is_move;
      end
      ST_DIFF:   cmd_o.diff_en  = 1'b1;
      ST_SQUARE: cmd_o.sq_en    = 1'b1;
      ST_CHECK:  cmd_o.check_en = 1'b1;
      ST_EMIT_ONE: begin
        cmd_o.emit      = sts_i.out_free;
        cmd_o.emit_kind = sts_i.is_move ? EV_MOVE : EV_DOWN;
        cmd_o.emit_last = 1'b1;
      end
      ST_EMIT_UP: begin
        cmd_o.emit      = sts_i.out_free;
        cmd_o.emit_kind = EV_UP;
        cmd_o.emit_last = !sts_i.armed_snap;
      end
      ST_EMIT_CLICK: begin
        cmd_o.emit      = sts_i.out_free;
        cmd_o.emit_kind = sts_i.long_snap ? EV_LONG : EV_CLICK;
        cmd_o.emit_last = 1'b1;
      end
      default: begin
        cmd_o     = '0;
        in_tready = 1'b0;
      end
    endcase
  end

`ifndef ASSERT_OFF
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_o.emit |-> sts_i.out_free)
    else $error("Result emitted while the output register was occupied.");

  a_load_decode: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_o.load |=> state_r == ST_DECODE)
    else $error("Accepted beat was not decoded in the following cycle.");

  a_one_action: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd_o.load, cmd_o.diff_en, cmd_o.sq_en, cmd_o.check_en, cmd_o.emit}))
    else $error("Controller issued more than one datapath action at once.");

  a_click_after_up: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_EMIT_CLICK |->
      ($past(state_r) == ST_EMIT_UP || $past(state_r) == ST_EMIT_CLICK))
    else $error("Click result not preceded by an up result.");
`endif

endmodule

// File: hw/rtl/clld_dp.sv
// Datapath of the click and long-click detector: button state, distance check,
// hold-time compare and the output register. Depends on clld_pkg.
module clld_dp import clld_pkg::*; #(
  parameter int NUM_BUTTONS = NUM_BUTTONS_DEF,
  parameter int COORD_BITS  = COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  clld_cmd_t                    cmd_i,
  output clld_sts_t                    sts_o,
  input  logic [1:0]                   in_cmd,
  input  logic signed [COORD_BITS-1:0] in_x,
  input  logic signed [COORD_BITS-1:0] in_y,
  input  logic [BTN_BITS-1:0]          in_btn,
  input  logic [TS_BITS-1:0]           in_ts,
  input  logic [CFG_BITS-1:0]          click_radius,
  input  logic [CFG_BITS-1:0]          long_click_delay,
  input  logic                         out_tready,
  output logic                         out_tvalid,
  output logic [2:0]                   out_kind,
  output logic [BTN_BITS-1:0]          out_btn,
  output logic signed [COORD_BITS-1:0] out_x,
  output logic signed [COORD_BITS-1:0] out_y,
  output logic                         out_last
);

  localparam int BW   = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
  localparam int SQW  = 2 * COORD_BITS;
  localparam int SUMW = SQW + 1;
  localparam int R2W  = 2 * CFG_BITS;
  localparam int CMPW = (SUMW > R2W) ? SUMW : R2W;

  logic [1:0]                   cmd_r;
  logic signed [COORD_BITS-1:0] x_r;
  logic signed [COORD_BITS-1:0] y_r;
  logic [BTN_BITS-1:0]          btn_r;
  logic [TS_BITS-1:0]           ts_r;

  logic [NUM_BUTTONS-1:0]       pressed_r;
  logic [NUM_BUTTONS-1:0]       armed_r;
  logic signed [COORD_BITS-1:0] down_x_r [NUM_BUTTONS];
  logic signed [COORD_BITS-1:0] down_y_r [NUM_BUTTONS];
  logic [TS_BITS-1:0]           down_time_r [NUM_BUTTONS];
  logic signed [COORD_BITS-1:0] last_x_r;
  logic signed [COORD_BITS-1:0] last_y_r;

  logic [BW-1:0]                btn_cnt_r;
  logic [R2W-1:0]               r2_r;
  logic [COORD_BITS-1:0]        dx_r;
  logic [COORD_BITS-1:0]        dy_r;
  logic                         act_r;
  logic                         act2_r;
  logic [SQW-1:0]               dx2_r;
  logic [SQW-1:0]               dy2_r;
  logic                         armed_snap_r;
  logic                         long_snap_r;

  logic                         out_valid_r;
  logic [2:0]                   out_kind_r;
  logic [BTN_BITS-1:0]          out_btn_r;
  logic signed [COORD_BITS-1:0] out_x_r;
  logic signed [COORD_BITS-1:0] out_y_r;
  logic                         out_last_r;

  logic [BW-1:0]                bidx;
  logic signed [COORD_BITS-1:0] sel_x;
  logic signed [COORD_BITS-1:0] sel_y;
  logic [COORD_BITS:0]          ddx;
  logic [COORD_BITS:0]          ddy;
  logic [COORD_BITS:0]          adx;
  logic [COORD_BITS:0]          ady;
  logic [SUMW-1:0]              dist2;
  logic                         far;
  logic [TS_BITS-1:0]           held;
  logic                         long_nxt;
  logic                         out_free;

  assign bidx  = BW'(btn_r);
  assign sel_x = down_x_r[btn_cnt_r];
  assign sel_y = down_y_r[btn_cnt_r];
  assign ddx   = {x_r[COORD_BITS-1], x_r} - {sel_x[COORD_BITS-1], sel_x};
  assign ddy   = {y_r[COORD_BITS-1], y_r} - {sel_y[COORD_BITS-1], sel_y};
  assign adx   = ddx[COORD_BITS] ? ((COORD_BITS+1)'(0) - ddx) : ddx;
  assign ady   = ddy[COORD_BITS] ? ((COORD_BITS+1)'(0) - ddy) : ddy;
  assign dist2 = SUMW'(dx2_r) + SUMW'(dy2_r);
  assign far   = CMPW'(dist2) > CMPW'(r2_r);
  assign held     = ts_r - down_time_r[bidx];
  assign long_nxt = held >= TS_BITS'(long_click_delay);
  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    sts_o            = '0;
    sts_o.is_down    = cmd_r == CMD_DOWN;
    sts_o.is_up      = cmd_r == CMD_UP;
    sts_o.is_move    = cmd_r == CMD_MOVE;
    sts_o.btn_ok     = 32'(btn_r) < 32'(NUM_BUTTONS);
    sts_o.armed_snap = armed_snap_r;
    sts_o.long_snap  = long_snap_r;
    sts_o.last_btn   = btn_cnt_r == BW'(NUM_BUTTONS - 1);
    sts_o.out_free   = out_free;
  end

  always_ff @(posedge clk) begin
    if (cmd_i.load) begin
      cmd_r <= in_cmd;
      x_r   <= in_x;
      y_r   <= in_y;
      btn_r <= in_btn;
      ts_r  <= in_ts;
    end
    if (cmd_i.move_start) begin
      r2_r <= R2W'(click_radius) * R2W'(click_radius);
    end
    if (cmd_i.diff_en) begin
      dx_r  <= adx[COORD_BITS-1:0];
      dy_r  <= ady[COORD_BITS-1:0];
      act_r <= pressed_r[btn_cnt_r] && armed_r[btn_cnt_r];
    end
    if (cmd_i.sq_en) begin
      dx2_r  <= SQW'(dx_r) * SQW'(dx_r);
      dy2_r  <= SQW'(dy_r) * SQW'(dy_r);
      act2_r <= act_r;
    end
    if (cmd_i.apply_up) begin
      armed_snap_r <= armed_r[bidx];
      long_snap_r  <= long_nxt;
    end
    if (cmd_i.emit) begin
      out_kind_r <= cmd_i.emit_kind;
      out_btn_r  <= (cmd_i.emit_kind == EV_MOVE) ? BTN_NONE : btn_r;
      out_x_r    <= last_x_r;
      out_y_r    <= last_y_r;
      out_last_r <= cmd_i.emit_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pressed_r   <= '0;
      armed_r     <= '1;
      last_x_r    <= '0;
      last_y_r    <= '0;
      btn_cnt_r   <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_BUTTONS; i++) begin
        down_x_r[i]    <= '0;
        down_y_r[i]    <= '0;
        down_time_r[i] <= '0;
      end
    end else begin
      if (cmd_i.set_pos) begin
        last_x_r <= x_r;
        last_y_r <= y_r;
      end
      if (cmd_i.apply_down) begin
        pressed_r[bidx]   <= 1'b1;
        down_x_r[bidx]    <= x_r;
        down_y_r[bidx]    <= y_r;
        down_time_r[bidx] <= ts_r;
      end
      if (cmd_i.apply_up) begin
        pressed_r[bidx] <= 1'b0;
        armed_r[bidx]   <= 1'b1;
      end
      if (cmd_i.move_start) begin
        btn_cnt_r <= '0;
      end else if (cmd_i.check_en) begin
        if (act2_r && far) begin
          armed_r[btn_cnt_r] <= 1'b0;
        end
        btn_cnt_r <= btn_cnt_r + 1'b1;
      end
      if (cmd_i.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_kind   = out_kind_r;
  assign out_btn    = out_btn_r;
  assign out_x      = out_x_r;
  assign out_y      = out_y_r;
  assign out_last   = out_last_r;

`ifndef ASSERT_OFF
  a_cancel_on_check: assert property (@(posedge clk) disable iff (!rst_n)
    (|($past(armed_r) & ~armed_r)) |-> $past(cmd_i.check_en))
    else $error("Click cancelled outside a distance check.");
`endif

endmodule
